@@ hw/rtl/cp866_to_html_entity_encoder_macros.svh @@
// ----------------------------------------------------------------------------
// cp866 encoder assertion macros
// shared assertion wrappers, clocked on the rising edge, off during reset
// ----------------------------------------------------------------------------
`ifndef CP866_TO_HTML_ENTITY_ENCODER_MACROS_SVH
`define CP866_TO_HTML_ENTITY_ENCODER_MACROS_SVH

// property must hold at every edge out of reset
`define CP866_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define CP866_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `CP866_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

@@ hw/rtl/cp866_pkg.sv @@
// ----------------------------------------------------------------------------
// cp866 encoder package
// character codes, stage payload types and mapping helpers
// ----------------------------------------------------------------------------
package cp866_pkg;

  localparam int unsigned CodeW = 14;  // largest code point is 9616

  localparam logic [7:0] CHAR_AMP  = 8'h26;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_LT   = 8'h3C;
  localparam logic [7:0] CHAR_GT   = 8'h3E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  typedef struct packed {
    logic [3:0]       digit;
    logic [CodeW-1:0] rem;
  } dig_rem_t;

  typedef struct packed {
    logic             entity;
    logic [7:0]       raw;
    logic [CodeW-1:0] code;
  } s1_t;

  typedef struct packed {
    logic       entity;
    logic [7:0] raw;
    logic [3:0] d3;
    logic [9:0] rem;
  } s2_t;

  typedef struct packed {
    logic       entity;
    logic [7:0] raw;
    logic [3:0] d3;
    logic [3:0] d2;
    logic [6:0] rem;
  } s3_t;

  typedef struct packed {
    logic            entity;
    logic [7:0]      raw;
    logic [3:0][3:0] digits;    // most significant first, index 0
    logic [2:0]      last_pos;
  } s4_t;

  // box drawing and block codes for bytes 179..223
  function automatic logic [CodeW-1:0] box_code(input logic [5:0] idx);
    logic [CodeW-1:0] c;
    case (idx)
      6'd0:  c = 14'h2502;  6'd1:  c = 14'h2524;  6'd2:  c = 14'h2561;
      6'd3:  c = 14'h2562;  6'd4:  c = 14'h2556;  6'd5:  c = 14'h2555;
      6'd6:  c = 14'h2563;  6'd7:  c = 14'h2551;  6'd8:  c = 14'h2557;
      6'd9:  c = 14'h255d;  6'd10: c = 14'h255c;  6'd11: c = 14'h255b;
      6'd12: c = 14'h2510;  6'd13: c = 14'h2514;  6'd14: c = 14'h2534;
      6'd15: c = 14'h252c;  6'd16: c = 14'h251c;  6'd17: c = 14'h2500;
      6'd18: c = 14'h253c;  6'd19: c = 14'h255e;  6'd20: c = 14'h255f;
      6'd21: c = 14'h255a;  6'd22: c = 14'h2554;  6'd23: c = 14'h2569;
      6'd24: c = 14'h2566;  6'd25: c = 14'h2560;  6'd26: c = 14'h2550;
      6'd27: c = 14'h256c;  6'd28: c = 14'h2567;  6'd29: c = 14'h2568;
      6'd30: c = 14'h2564;  6'd31: c = 14'h2565;  6'd32: c = 14'h2559;
      6'd33: c = 14'h2558;  6'd34: c = 14'h2552;  6'd35: c = 14'h2553;
      6'd36: c = 14'h256b;  6'd37: c = 14'h256a;  6'd38: c = 14'h2518;
      6'd39: c = 14'h250c;  6'd40: c = 14'h2588;  6'd41: c = 14'h2584;
      6'd42: c = 14'h258c;  6'd43: c = 14'h2590;  6'd44: c = 14'h2580;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [CodeW-1:0] map_code(input logic [7:0] b);
    logic [CodeW-1:0] c;
    logic [7:0]       off;
    off = b - 8'd179;
    if (b inside {[8'd128:8'd175]}) begin
      c = {6'b0, b} + 14'd912;
    end else if (b inside {[8'd224:8'd239]}) begin
      c = {6'b0, b} + 14'd864;
    end else if (b inside {[8'd179:8'd223]}) begin
      c = box_code(off[5:0]);
    end else begin
      c = {6'b0, b};
    end
    return c;
  endfunction

  // one decimal digit by parallel compares against constant multiples
  function automatic dig_rem_t dec_digit(input logic [CodeW-1:0] value,
                                         input logic [CodeW-1:0] unit);
    dig_rem_t r;
    r.digit = '0;
    r.rem   = value;
    for (int k = 1; k < 10; k++) begin
      if (value >= CodeW'(k) * unit) begin
        r.digit = 4'(k);
        r.rem   = value - CodeW'(k) * unit;
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/cp866_to_html_entity_encoder.sv @@
// ----------------------------------------------------------------------------
// cp866 to html entity encoder
// four stage pipeline: map, thousands, hundreds, tens/ones and serializer
// ----------------------------------------------------------------------------
// a byte passes the map, thousands, hundreds and tens/ones registers before its first character is valid
// throughput: one byte per cycle when it yields one character and out_ready_i
//   is high; an entity run holds the serializer stage for its 5 to 7 characters
// reset: pipeline empties, en_q (transcode enable) comes up as 1
module cp866_to_html_entity_encoder
  import cp866_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       run_last_o
);

  `include "cp866_to_html_entity_encoder_macros.svh"

  logic       en_q;
  logic       v1_q, v2_q, v3_q, v4_q;
  s1_t        p1_q, p1_d;
  s2_t        p2_q, p2_d;
  s3_t        p3_q, p3_d;
  s4_t        p4_q, p4_d;
  logic [2:0] pos_q, pos_d;
  logic       rdy1, rdy2, rdy3, rdy4;
  logic [1:0] dig_idx;
  dig_rem_t   thou, hund, tens;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b1;
    end else if (cfg_we_i) begin
      en_q <= cfg_wdata_i;
    end
  end

  // stall chain
  assign rdy4       = !v4_q || (out_ready_i && run_last_o);
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // stage 1: code point mapping
  always_comb begin
    p1_d.raw    = in_byte_i;
    p1_d.code   = map_code(in_byte_i);
    p1_d.entity = en_q && (p1_d.code >= CodeW'(128) ||
                  in_byte_i inside {CHAR_AMP, CHAR_LT, CHAR_GT});
  end

  // stage 2: thousands digit
  always_comb begin
    thou        = dec_digit(p1_q.code, CodeW'(1000));
    p2_d.entity = p1_q.entity;
    p2_d.raw    = p1_q.raw;
    p2_d.d3     = thou.digit;
    p2_d.rem    = thou.rem[9:0];
  end

  // stage 3: hundreds digit
  always_comb begin
    hund        = dec_digit({4'b0, p2_q.rem}, CodeW'(100));
    p3_d.entity = p2_q.entity;
    p3_d.raw    = p2_q.raw;
    p3_d.d3     = p2_q.d3;
    p3_d.d2     = hund.digit;
    p3_d.rem    = hund.rem[6:0];
  end

  // stage 4: tens and ones, drop leading zeros
  always_comb begin
    tens        = dec_digit({7'b0, p3_q.rem}, CodeW'(10));
    p4_d.entity = p3_q.entity;
    p4_d.raw    = p3_q.raw;
    if (p3_q.d3 != 4'd0) begin
      p4_d.digits   = {tens.rem[3:0], tens.digit, p3_q.d2, p3_q.d3};
      p4_d.last_pos = 3'd6;
    end else if (p3_q.d2 != 4'd0) begin
      p4_d.digits   = {4'd0, tens.rem[3:0], tens.digit, p3_q.d2};
      p4_d.last_pos = 3'd5;
    end else begin
      p4_d.digits   = {4'd0, 4'd0, tens.rem[3:0], tens.digit};
      p4_d.last_pos = 3'd4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) p1_q <= p1_d;
    if (rdy2 && v1_q)       p2_q <= p2_d;
    if (rdy3 && v2_q)       p3_q <= p3_d;
    if (rdy4 && v3_q)       p4_q <= p4_d;
  end

  // serializer position within the run
  always_comb begin
    pos_d = pos_q;
    if (out_valid_o && out_ready_i) begin
      pos_d = run_last_o ? 3'd0 : pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 3'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

  assign dig_idx     = 2'(pos_q - 3'd2);
  assign out_valid_o = v4_q;
  assign run_last_o  = !p4_q.entity || (pos_q == p4_q.last_pos);

  always_comb begin
    if (!p4_q.entity) begin
      out_char_o = p4_q.raw;
    end else begin
      case (pos_q)
        3'd0:    out_char_o = CHAR_AMP;
        3'd1:    out_char_o = CHAR_HASH;
        default: begin
          if (pos_q == p4_q.last_pos) begin
            out_char_o = CHAR_SEMI;
          end else begin
            out_char_o = CHAR_ZERO + {4'b0, p4_q.digits[dig_idx]};
          end
        end
      endcase
    end
  end

  `CP866_ASSERT(a_pos_only_in_entity, clk_i, rst_ni, (pos_q != 3'd0) |-> (v4_q && p4_q.entity), "serializer position set without an entity run")
  `CP866_ASSERT(a_pos_bounded, clk_i, rst_ni, (v4_q && p4_q.entity) |-> (pos_q <= p4_q.last_pos), "serializer position past end of run")
  `CP866_ASSERT(a_run_continues, clk_i, rst_ni, (out_valid_o && out_ready_i && !run_last_o) |=> out_valid_o, "entity run dropped before its last character")
  `CP866_ASSERT_NEVER(a_stall_needs_item, clk_i, rst_ni, !in_ready_o && !v1_q, "input stalled with empty first stage")

endmodule

@@ tb/cp866_encoder_checker.sv @@
// ----------------------------------------------------------------------------
// cp866 encoder checker
// watches the byte and character channels, predicts each byte's character
// run and compares every character transaction against the oldest prediction
// ----------------------------------------------------------------------------
module cp866_encoder_checker
  import cp866_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_char_i,
  input  logic       run_last_i,
  output int         error_count_o,
  output int         pending_o,
  output int         checked_o,
  output int         entities_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } run_char_t;

  run_char_t  char_queue[$];
  logic       transcode_en;

  // box drawing and block code points for bytes 179..223
  function automatic int unsigned box_point(input logic [7:0] b);
    case (b)
      8'd179: return 'h2502;  8'd180: return 'h2524;  8'd181: return 'h2561;
      8'd182: return 'h2562;  8'd183: return 'h2556;  8'd184: return 'h2555;
      8'd185: return 'h2563;  8'd186: return 'h2551;  8'd187: return 'h2557;
      8'd188: return 'h255d;  8'd189: return 'h255c;  8'd190: return 'h255b;
      8'd191: return 'h2510;  8'd192: return 'h2514;  8'd193: return 'h2534;
      8'd194: return 'h252c;  8'd195: return 'h251c;  8'd196: return 'h2500;
      8'd197: return 'h253c;  8'd198: return 'h255e;  8'd199: return 'h255f;
      8'd200: return 'h255a;  8'd201: return 'h2554;  8'd202: return 'h2569;
      8'd203: return 'h2566;  8'd204: return 'h2560;  8'd205: return 'h2550;
      8'd206: return 'h256c;  8'd207: return 'h2567;  8'd208: return 'h2568;
      8'd209: return 'h2564;  8'd210: return 'h2565;  8'd211: return 'h2559;
      8'd212: return 'h2558;  8'd213: return 'h2552;  8'd214: return 'h2553;
      8'd215: return 'h256b;  8'd216: return 'h256a;  8'd217: return 'h2518;
      8'd218: return 'h250c;  8'd219: return 'h2588;  8'd220: return 'h2584;
      8'd221: return 'h258c;  8'd222: return 'h2590;  8'd223: return 'h2580;
      default: return b;
    endcase
  endfunction

  function automatic int unsigned unicode_of(input logic [7:0] b);
    if (b >= 8'd128 && b <= 8'd175) return int'(b) + 912;
    if (b >= 8'd224 && b <= 8'd239) return int'(b) + 864;
    return box_point(b);
  endfunction

  // queue the character run that one byte turns into
  task automatic queue_run(input logic [7:0] b, input logic en);
    int unsigned cp;
    logic [7:0]  digits[$];
    run_char_t   rc;
    cp = unicode_of(b);
    if (!en || !(cp >= 128 || b == CHAR_AMP || b == CHAR_LT || b == CHAR_GT)) begin
      rc.ch   = b;
      rc.last = 1'b1;
      char_queue.push_back(rc);
    end else begin
      do begin
        digits.push_front(CHAR_ZERO + 8'(cp % 10));
        cp = cp / 10;
      end while (cp != 0);
      rc.last = 1'b0;
      rc.ch   = CHAR_AMP;
      char_queue.push_back(rc);
      rc.ch   = CHAR_HASH;
      char_queue.push_back(rc);
      foreach (digits[i]) begin
        rc.ch = digits[i];
        char_queue.push_back(rc);
      end
      rc.ch   = CHAR_SEMI;
      rc.last = 1'b1;
      char_queue.push_back(rc);
      entities_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    run_char_t want;
    if (!rst_ni) begin
      transcode_en  <= 1'b1;
      char_queue.delete();
      error_count_o = 0;
      pending_o     = 0;
      checked_o     = 0;
      entities_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (char_queue.size() == 0) begin
          $display("%0t: char transaction with none expected, got %h last %b",
                   $time, out_char_i, run_last_i);
          error_count_o++;
        end else begin
          want = char_queue.pop_front();
          checked_o++;
          if (out_char_i !== want.ch) begin
            $display("%0t: out_char expected %h got %h", $time, want.ch, out_char_i);
            error_count_o++;
          end
          if (run_last_i !== want.last) begin
            $display("%0t: run_last expected %b got %b", $time, want.last, run_last_i);
            error_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) queue_run(in_byte_i, transcode_en);
      if (cfg_we_i) transcode_en <= cfg_wdata_i;
      pending_o = char_queue.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// cp866 encoder testbench
// directed corner bytes then random cp866 text under both transcode
// settings, with random idle bursts on both channels but in the last stretch
// ----------------------------------------------------------------------------
module tb;
  import cp866_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int SettleCycles = 10;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_char_o;
  logic       run_last_o;

  int         error_count;
  int         pending;
  int         checked;
  int         entities;
  int         cycles;
  int         bytes_sent;
  logic       quiet;

  logic [7:0] corner_bytes [0:17] = '{
    8'd0, 8'd127, CHAR_AMP, CHAR_LT, CHAR_GT, 8'h41, 8'd128, 8'd175, 8'd176,
    8'd178, 8'd179, 8'd222, 8'd223, 8'd224, 8'd239, 8'd240, 8'd255, 8'h3D
  };

  cp866_to_html_entity_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .run_last_o  (run_last_o)
  );

  cp866_encoder_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_char_i    (out_char_o),
    .run_last_i    (run_last_o),
    .error_count_o (error_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .entities_o    (entities)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d characters still expected", cycles, pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver back-pressure in bursts
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  // mostly cyrillic and box drawing text, with markup characters mixed in
  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(32, 126));
      1: return 8'($urandom_range(128, 175));
      2: return 8'($urandom_range(224, 239));
      3: return 8'($urandom_range(179, 223));
      4: begin
        case ($urandom_range(0, 2))
          0: return CHAR_AMP;
          1: return CHAR_LT;
          default: return CHAR_GT;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_byte(text_byte());
  endtask

  // wait until every predicted character has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_transcode(input logic en);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'b0;
    in_valid_i  <= 1'b0;
    in_byte_i   <= 8'd0;
    quiet       = 1'b0;
    bytes_sent  = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner bytes with the reset setting (transcoding on)
    foreach (corner_bytes[i]) send_byte(corner_bytes[i]);

    // pass-through with transcoding off, mostly of entity-worthy bytes
    write_transcode(1'b0);
    send_byte(8'd0);
    send_byte(CHAR_AMP);
    send_byte(8'd128);
    send_byte(8'd222);
    send_byte(8'd255);

    write_transcode(1'b1);
    send_random(150);
    write_transcode(1'b0);
    send_random(120);
    write_transcode(1'b1);

    // last stretch runs without idle bursts
    quiet = 1'b1;
    send_random(120);
    drain();

    $display("sent %0d cp866 bytes under both transcode settings", bytes_sent);
    $display("checked %0d characters, %0d entity runs", checked, entities);
    if (error_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ cp866_to_html_entity_encoder.f @@
+incdir+hw/rtl
hw/rtl/cp866_pkg.sv
hw/rtl/cp866_to_html_entity_encoder.sv
tb/cp866_encoder_checker.sv
tb/tb.sv
